// ===== rtl/spq_pkg.sv =====
// shared types and constants of the sorted priority queue
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int PRIO_W      = 16;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 3;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     valid;
        logic     tail;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// one storage cell of the sorted chain
`default_nettype none

module spq_cell (
    input  wire logic               aclk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire spq_pkg::entry_t    new_entry,
    input  wire spq_pkg::entry_t    head_entry,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire logic               left_le,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    le
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // this cell stays ahead of the new entry
    assign le    = ctrl.valid && (entry_reg.prio <= new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            spq_pkg::OP_INSERT: begin
                if (!le) begin
                    entry_next = left_le ? new_entry : left_entry;
                end
            end
            spq_pkg::OP_SHIFT: begin
                entry_next = right_entry;
            end
            spq_pkg::OP_ROTATE: begin
                entry_next = ctrl.tail ? head_entry : right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// top level of the sorted priority queue: cell chain, occupancy and result beats
//
//   channel  | ports                                            | dir
//   ---------+--------------------------------------------------+----
//   request  | s_valid s_ready s_action s_data s_priority_req   | in
//   result   | m_valid m_ready m_status m_out_data              | out
//            | m_out_priority m_last                            |
//
// insert and delete update the chain as their request beat is taken; the result
// beat is registered and the next request beat is taken no earlier than the cycle
// that result leaves; a listing of n entries gives n beats after its request beat,
// rotating the chain once round so it is left as it was; requests wait
// stalls on m_ready hold the result register and stop request beats
// reset (aresetn low at a clock edge) empties the queue and drops any result
`default_nettype none

module sorted_priority_queue (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [spq_pkg::ACTION_W-1:0]        s_action,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   s_data,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   s_priority_req,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [spq_pkg::STATUS_W-1:0]             m_status,
    output logic signed [spq_pkg::DATA_W-1:0]        m_out_data,
    output logic signed [spq_pkg::PRIO_W-1:0]        m_out_priority,
    output logic                                     m_last
);

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

    state_t state_reg;

    logic [spq_pkg::OCC_W-1:0]       occ_reg;
    logic [spq_pkg::OCC_W-1:0]       list_cnt_reg;
    logic                            m_valid_reg;
    logic [spq_pkg::STATUS_W-1:0]    m_status_reg;
    logic signed [spq_pkg::DATA_W-1:0] m_data_reg;
    logic signed [spq_pkg::PRIO_W-1:0] m_prio_reg;
    logic                            m_last_reg;

    logic                            m_valid_next;
    logic [spq_pkg::STATUS_W-1:0]    m_status_next;
    logic signed [spq_pkg::DATA_W-1:0] m_data_next;
    logic signed [spq_pkg::PRIO_W-1:0] m_prio_next;
    logic                            m_last_next;

    logic out_free;
    logic s_fire;
    logic full;
    logic empty;
    logic list_emit;
    logic list_last;
    spq_pkg::cell_op_t op;

    spq_pkg::entry_t new_entry;
    spq_pkg::entry_t head_entry;
    spq_pkg::entry_t cell_entry [spq_pkg::QUEUE_DEPTH];
    logic            cell_le    [spq_pkg::QUEUE_DEPTH];

    // result register is free when empty or being drained this cycle
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign full      = (occ_reg == spq_pkg::OCC_W'(spq_pkg::QUEUE_DEPTH));
    assign empty     = (occ_reg == '0);
    assign list_emit = (state_reg == ST_LIST) && out_free;
    assign list_last = ((list_cnt_reg + spq_pkg::OCC_W'(1)) == occ_reg);

    assign new_entry.prio = s_priority_req;
    assign new_entry.data = s_data;
    assign head_entry     = cell_entry[0];

    // one chain operation per cycle, shared by every cell
    always_comb begin
        op = spq_pkg::OP_HOLD;
        if (s_fire && (s_action == spq_pkg::ACT_INSERT) && !full) begin
            op = spq_pkg::OP_INSERT;
        end else if (s_fire && (s_action == spq_pkg::ACT_DELETE) && !empty) begin
            op = spq_pkg::OP_SHIFT;
        end else if (list_emit) begin
            op = spq_pkg::OP_ROTATE;
        end
    end

    // the chain: head at cell 0, each cell sees its two neighbours
    for (genvar i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
        spq_pkg::cell_ctrl_t ctrl;
        spq_pkg::entry_t     left_entry;
        spq_pkg::entry_t     right_entry;
        logic                left_le;

        assign ctrl.op    = op;
        assign ctrl.valid = (occ_reg > spq_pkg::OCC_W'(i));
        assign ctrl.tail  = (occ_reg == spq_pkg::OCC_W'(i + 1));

        if (i == 0) begin : g_first
            // nothing ahead of the head, so it takes the new entry on a miss
            assign left_entry = new_entry;
            assign left_le    = 1'b1;
        end else begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_le    = cell_le[i-1];
        end

        if (i == spq_pkg::QUEUE_DEPTH - 1) begin : g_end
            // past the end: only ever lands in an empty cell
            assign right_entry = cell_entry[i];
        end else begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .head_entry  (head_entry),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .le          (cell_le[i])
        );
    end

    // next result beat: a request beat or a listing step loads it,
    // otherwise it clears once taken
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_prio_next   = m_prio_reg;
        m_last_next   = m_last_reg;
        if (s_fire) begin
            m_data_next = '0;
            m_prio_next = '0;
            m_last_next = 1'b1;
            case (s_action)
                spq_pkg::ACT_INSERT: begin
                    m_valid_next  = 1'b1;
                    m_status_next = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_INSERTED;
                end
                spq_pkg::ACT_DELETE: begin
                    m_valid_next = 1'b1;
                    if (empty) begin
                        m_status_next = spq_pkg::ST_UNDERFLOW;
                    end else begin
                        m_status_next = spq_pkg::ST_DELETED;
                        m_data_next   = head_entry.data;
                        m_prio_next   = head_entry.prio;
                    end
                end
                spq_pkg::ACT_LIST: begin
                    if (empty) begin
                        m_valid_next  = 1'b1;
                        m_status_next = spq_pkg::ST_EMPTY;
                    end
                end
                default: begin
                    // meaningless action: taken, no beat
                end
            endcase
        end else if (list_emit) begin
            m_valid_next  = 1'b1;
            m_status_next = spq_pkg::ST_LISTED;
            m_data_next   = head_entry.data;
            m_prio_next   = head_entry.prio;
            m_last_next   = list_last;
        end
    end

    // control state, occupancy and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            list_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            m_status_reg <= m_status_next;
            m_data_reg   <= m_data_next;
            m_prio_reg   <= m_prio_next;
            m_last_reg   <= m_last_next;
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_action)
                            spq_pkg::ACT_INSERT: begin
                                if (!full) begin
                                    occ_reg <= occ_reg + spq_pkg::OCC_W'(1);
                                end
                            end
                            spq_pkg::ACT_DELETE: begin
                                if (!empty) begin
                                    occ_reg <= occ_reg - spq_pkg::OCC_W'(1);
                                end
                            end
                            spq_pkg::ACT_LIST: begin
                                if (!empty) begin
                                    state_reg    <= ST_LIST;
                                    list_cnt_reg <= '0;
                                end
                            end
                            default: begin
                                // meaningless action: queue untouched
                            end
                        endcase
                    end
                end
                ST_LIST: begin
                    if (list_emit) begin
                        list_cnt_reg <= list_cnt_reg + spq_pkg::OCC_W'(1);
                        if (list_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_data     = m_data_reg;
    assign m_out_priority = m_prio_reg;
    assign m_last         = m_last_reg;

endmodule

`default_nettype wire
